>>> design/adc_frame_unpacker_defines.svh
// assertion macros for the adc frame unpacker
`ifndef ADC_FRAME_UNPACKER_DEFINES_SVH
`define ADC_FRAME_UNPACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AFU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adc_frame_unpacker: same-cycle check failed");

// next-cycle implication, checked outside reset
`define AFU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adc_frame_unpacker: next-cycle check failed");

`endif

>>> design/afu_pkg.sv
`default_nettype none

package afu_pkg;

   localparam int FRAME_WORDS = 16;
   localparam int DATA_WORDS  = 15;
   localparam int NUM_SAMPLES = 40;
   localparam int NUM_RATES   = 10;
   localparam int SAMPLE_BITS = 12;
   localparam int RATE_BASE   = 4;
   localparam int SYNC_WORDS  = 4;
   localparam logic [7:0] SYNC_ID = 8'd10;

   // result kind codes
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_SYNC   = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   typedef struct packed {
      logic [31:0] raw_word;
      logic        bank_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  channel;
      logic [31:0] frame_tag;
      logic [5:0]  item_index;
      logic [11:0] sample_value;
      logic [63:0] sync_counter;
      logic [63:0] sync_latch;
      logic [31:0] rate_value;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_HALTED,
      ST_SAMPLES,
      ST_RATES,
      ST_ERROR
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       wr_en;
      logic [3:0] wr_addr;
      logic       id_en;
      logic       issue;
      logic [1:0] issue_kind;
      logic [5:0] issue_idx;
      logic       issue_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       adv;
      logic [1:0] id_class;
   } sts_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

`default_nettype wire

>>> design/afu_ctrl.sv
`default_nettype none

module afu_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            bank_start,
   output logic                 req_stall,
   input  wire afu_pkg::sts_type sts,
   output afu_pkg::cmd_type     cmd
);
   import afu_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] pos_ff, pos_in;
   logic [5:0] idx_ff, idx_in;
   logic       accept;
   logic [3:0] eff_pos;
   logic       is_id;
   logic       last_sample, last_rate;

   assign accept      = req_valid && !req_stall;
   assign eff_pos     = bank_start ? 4'd0 : pos_ff;
   assign is_id       = (eff_pos == 4'(FRAME_WORDS - 1));
   assign last_sample = (idx_ff == 6'(NUM_SAMPLES - 1));
   assign last_rate   = (idx_ff == 6'(NUM_RATES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         pos_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         idx_ff   <= idx_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (accept && is_id) begin
               case (sts.id_class)
                  KIND_SAMPLE: state_in = ST_SAMPLES;
                  KIND_SYNC:   state_in = ST_RATES;
                  default:     state_in = ST_ERROR;
               endcase
            end
         end
         ST_HALTED: begin
            if (accept && bank_start) state_in = ST_FILL;
         end
         ST_SAMPLES: begin
            if (sts.adv && last_sample) state_in = ST_FILL;
         end
         ST_RATES: begin
            if (sts.adv && last_rate) state_in = ST_FILL;
         end
         ST_ERROR: begin
            if (sts.adv) state_in = ST_HALTED;
         end
         default: state_in = ST_FILL;
      endcase
   end

   // word position and item counters
   always_comb begin
      pos_in = pos_ff;
      idx_in = idx_ff;
      case (state_ff)
         ST_FILL: begin
            if (accept) begin
               pos_in = is_id ? 4'd0 : eff_pos + 4'd1;
               idx_in = '0;
            end
         end
         ST_HALTED: begin
            if (accept && bank_start) pos_in = 4'd1;
         end
         ST_SAMPLES, ST_RATES: begin
            if (sts.adv) idx_in = idx_ff + 6'd1;
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = 1'b1;
      cmd            = '0;
      cmd.wr_addr    = eff_pos;
      cmd.issue_idx  = idx_ff;
      case (state_ff)
         ST_FILL: begin
            req_stall = 1'b0;
            cmd.wr_en = accept && !is_id;
            cmd.id_en = accept && is_id;
         end
         ST_HALTED: begin
            req_stall = 1'b0;
            cmd.wr_en = accept && bank_start;
         end
         ST_SAMPLES: begin
            cmd.issue      = sts.adv;
            cmd.issue_kind = KIND_SAMPLE;
            cmd.issue_last = last_sample;
         end
         ST_RATES: begin
            cmd.issue      = sts.adv;
            cmd.issue_kind = KIND_SYNC;
            cmd.issue_last = last_rate;
         end
         ST_ERROR: begin
            cmd.issue      = sts.adv;
            cmd.issue_kind = KIND_ERROR;
            cmd.issue_idx  = '0;
            cmd.issue_last = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> design/afu_dp.sv
`default_nettype none

module afu_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire afu_pkg::req_type req_data,
   input  wire afu_pkg::cmd_type cmd,
   output afu_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output afu_pkg::rsp_type      rsp_data
);
   import afu_pkg::*;

   logic [31:0] mem_ff [DATA_WORDS];
   logic [31:0] head_ff [SYNC_WORDS];
   logic [31:0] tag_ff;
   logic [31:0] word;

   // read stage
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_kind_ff;
   logic [5:0]  s1_idx_ff;
   logic        s1_last_ff;
   logic [4:0]  s1_off_ff;
   logic [31:0] s1_tag_ff;
   logic [63:0] s1_counter_ff, s1_latch_ff;
   logic [31:0] rd_a_ff, rd_b_ff;

   // output stage
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        adv;
   logic [8:0]  bit_pos;
   logic [3:0]  word_sel, addr_a, addr_b;
   logic [63:0] pair_shift;

   assign word = swap32(req_data.raw_word);
   assign adv  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sts.adv = adv;
      if (word[31:24] < SYNC_ID) sts.id_class = KIND_SAMPLE;
      else if (word[31:24] == SYNC_ID) sts.id_class = KIND_SYNC;
      else sts.id_class = KIND_ERROR;
   end

   assign bit_pos  = 9'(cmd.issue_idx) * 9'(SAMPLE_BITS);
   assign word_sel = bit_pos[8:5];
   assign addr_a   = (cmd.issue_kind == KIND_SYNC) ?
                     4'(RATE_BASE) + cmd.issue_idx[3:0] : word_sel;
   assign addr_b   = (word_sel == 4'(DATA_WORDS - 1)) ? word_sel : word_sel + 4'd1;

   // frame store and the first words kept aside for sync frames
   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem_ff[cmd.wr_addr] <= word;
      if (cmd.wr_en && cmd.wr_addr < 4'(SYNC_WORDS)) head_ff[cmd.wr_addr[1:0]] <= word;
      if (cmd.id_en) tag_ff <= word;
      if (cmd.issue) begin
         rd_a_ff       <= mem_ff[addr_a];
         rd_b_ff       <= mem_ff[addr_b];
         s1_kind_ff    <= cmd.issue_kind;
         s1_idx_ff     <= cmd.issue_idx;
         s1_last_ff    <= cmd.issue_last;
         s1_off_ff     <= bit_pos[4:0];
         s1_tag_ff     <= tag_ff;
         s1_counter_ff <= {head_ff[1], head_ff[0]};
         s1_latch_ff   <= {head_ff[3], head_ff[2]};
      end
   end

   assign pair_shift = {rd_b_ff, rd_a_ff} >> s1_off_ff;

   always_comb begin
      rsp_data_in           = '0;
      rsp_data_in.kind      = s1_kind_ff;
      rsp_data_in.channel   = s1_tag_ff[31:24];
      rsp_data_in.frame_tag = s1_tag_ff;
      rsp_data_in.last      = s1_last_ff;
      case (s1_kind_ff)
         KIND_SAMPLE: begin
            rsp_data_in.item_index   = s1_idx_ff;
            rsp_data_in.sample_value = pair_shift[11:0];
         end
         KIND_SYNC: begin
            rsp_data_in.item_index   = s1_idx_ff;
            rsp_data_in.sync_counter = s1_counter_ff;
            rsp_data_in.sync_latch   = s1_latch_ff;
            rsp_data_in.rate_value   = rd_a_ff;
         end
         default: begin
            rsp_data_in.item_index = '0;
         end
      endcase
   end

   assign s1_valid_in  = adv ? cmd.issue : s1_valid_ff;
   assign rsp_valid_in = adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> design/adc_frame_unpacker.sv
// adc frame unpacker
// req channel: one 32-bit big-endian bank word per beat, with bank_start
// marking word 0 of a new bank; a partial frame is dropped at a bank start.
// rsp channel: one result per beat. words 0 to 14 of a frame give no result;
// word 15 (the frame id) gives 40 sample results, 10 sync rate results or one
// error result, with last set on the final one of the frame.
// flow: data words are taken one per cycle. after the frame id beat the
// req side stalls while results are issued, one per cycle unless rsp_stall
// holds them, from the frame store's two registered read ports through the
// read stage and the output register.
// rsp stall: the output register and the read stage hold, issuing pauses,
// nothing is lost. an error result halts framing: words are swallowed until
// one carries bank_start.
// reset: framing restarts at word 0, not halted, no result pending. the
// frame store itself is not cleared.
`default_nettype none

`include "adc_frame_unpacker_defines.svh"

module adc_frame_unpacker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire afu_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output afu_pkg::rsp_type      rsp_data
);
   import afu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // controller: framing position, halt state, item sequencing
   afu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .bank_start (req_data.bank_start),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: byte swap, frame store, sample extraction, output register
   afu_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // no input beat is taken while results are being issued
   `AFU_ASSERT_NOW(a_no_accept_on_issue, clock, reset, req_valid && !req_stall, !cmd.issue)
   // an error result always closes its frame
   `AFU_ASSERT_NOW(a_error_is_last, clock, reset, rsp_valid && rsp_data.kind == KIND_ERROR, rsp_data.last)
   // an issued item reaches the read stage, so output is busy or filling next cycle
   `AFU_ASSERT_NEXT(a_issue_moves, clock, reset, cmd.issue && sts.adv, u_dp.s1_valid_ff || rsp_valid)

endmodule

`default_nettype wire
